@@ design/adne_pkg.sv @@
`timescale 1ns / 1ps

package adne_pkg;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_TYPE,
        PH_SKIP,
        PH_NAME,
        PH_DONE
    } t_phase;

    localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
    localparam logic [7:0] AD_NAME_CMPL     = 8'h09;

    localparam logic       KIND_CHAR        = 1'b0;
    localparam logic       KIND_SUMMARY     = 1'b1;

    localparam logic [5:0] MAX_NAME_LEN_RST = 6'd31;

    localparam int         FIFO_DEPTH       = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_char;
        logic       name_found;
        logic [5:0] name_length;
        logic       run_last;
    } t_result;

    // results produced by one accepted request, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

@@ design/adne_in_if.sv @@
`timescale 1ns / 1ps

interface adne_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [5:0] frame_len;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_len, output frame_last,
                    input ready);
    modport sink   (input valid, input data_byte, input frame_len, input frame_last,
                    output ready);
endinterface

@@ design/adne_out_if.sv @@
`timescale 1ns / 1ps

interface adne_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] name_char;
    logic       name_found;
    logic [5:0] name_length;
    logic       run_last;

    modport source (output valid, output kind, output name_char, output name_found,
                    output name_length, output run_last, input ready);
    modport sink   (input valid, input kind, input name_char, input name_found,
                    input name_length, input run_last, output ready);
endinterface

@@ design/adne_parser.sv @@
`timescale 1ns / 1ps

module adne_parser
    import adne_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 62
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic [5:0] i_frame_len,
    input  logic       i_frame_last,
    input  logic [5:0] i_max_name_len,
    output t_push      o_push
);

    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int SUM_W = ((OFF_W > 8) ? OFF_W : 8) + 1;
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_FRAME_BYTES);
    localparam logic [SUM_W-1:0] MAX_EXT = SUM_W'(MAX_FRAME_BYTES);

    t_phase           r_phase,     n_phase;
    logic [OFF_W-1:0] r_offset,    n_offset;
    logic [7:0]       r_remaining, n_remaining;
    logic [5:0]       r_chars,     n_chars;
    logic             r_found,     n_found;

    logic [5:0]       s_chars;
    logic             s_found;

    logic [SUM_W-1:0] w_flen_ext;
    logic [SUM_W-1:0] w_eff;
    logic [SUM_W-1:0] w_off_ext;
    logic [SUM_W-1:0] w_end_pos;
    logic [7:0]       w_rem_dec;
    logic             w_is_name;
    logic             w_emit;

    assign w_flen_ext = SUM_W'(i_frame_len);
    assign w_eff      = (w_flen_ext < MAX_EXT) ? w_flen_ext : MAX_EXT;
    assign w_off_ext  = SUM_W'(r_offset);
    assign w_end_pos  = w_off_ext + SUM_W'(i_data_byte);
    assign w_rem_dec  = r_remaining - 8'd1;
    assign w_is_name  = (i_data_byte == AD_NAME_CMPL) || (i_data_byte == AD_NAME_SHORT);
    assign w_emit     = (r_phase == PH_NAME) && (r_chars < i_max_name_len);

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        s_chars     = r_chars;
        s_found     = r_found;
        unique case (r_phase)
            PH_LEN: begin
                if ((w_off_ext >= w_eff) || (i_data_byte == 8'd0) || (w_end_pos >= w_eff)) begin
                    n_phase = PH_DONE;
                end else begin
                    n_remaining = i_data_byte;
                    n_phase     = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_remaining = w_rem_dec;
                if (w_is_name) begin
                    s_found = 1'b1;
                    n_phase = (w_rem_dec == 8'd0) ? PH_DONE : PH_NAME;
                end else begin
                    n_phase = (w_rem_dec == 8'd0) ? PH_LEN : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_remaining = w_rem_dec;
                if (w_rem_dec == 8'd0) begin
                    n_phase = PH_LEN;
                end
            end
            PH_NAME: begin
                if (w_emit) begin
                    s_chars = r_chars + 6'd1;
                end
                n_remaining = w_rem_dec;
                if (w_rem_dec == 8'd0) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        n_offset = (r_offset < OFF_MAX) ? r_offset + OFF_W'(1) : r_offset;
        n_chars  = s_chars;
        n_found  = s_found;

        if (i_frame_last) begin
            n_phase     = PH_LEN;
            n_offset    = '0;
            n_remaining = 8'd0;
            n_chars     = 6'd0;
            n_found     = 1'b0;
        end
    end

    // results
    always_comb begin
        t_result v_char;
        t_result v_sum;
        v_char.kind        = KIND_CHAR;
        v_char.name_char   = i_data_byte;
        v_char.name_found  = 1'b0;
        v_char.name_length = 6'd0;
        v_char.run_last    = ~i_frame_last;
        v_sum.kind         = KIND_SUMMARY;
        v_sum.name_char    = 8'd0;
        v_sum.name_found   = s_found;
        v_sum.name_length  = s_chars;
        v_sum.run_last     = 1'b1;

        o_push.count  = 2'd0;
        o_push.first  = v_sum;
        o_push.second = v_sum;
        if (i_fire) begin
            if (w_emit) begin
                o_push.first = v_char;
                o_push.count = i_frame_last ? 2'd2 : 2'd1;
            end else if (i_frame_last) begin
                o_push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_offset    <= '0;
            r_remaining <= 8'd0;
            r_chars     <= 6'd0;
            r_found     <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_remaining <= n_remaining;
            r_chars     <= n_chars;
            r_found     <= n_found;
        end
    end

    a_found_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_phase == PH_NAME || r_phase == PH_DONE))
        else $error("found flag set outside name or done phase");

    a_chars_need_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chars != 6'd0) |-> r_found)
        else $error("characters counted without a name structure");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_frame_last) |=> (r_phase == PH_LEN && r_offset == '0 && !r_found))
        else $error("frame state not cleared after last byte");

endmodule

@@ design/adne_fifo.sv @@
`timescale 1ns / 1ps

module adne_fifo
    import adne_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] w_wr_next;

    assign w_wr_next = r_wr + PTR_W'(1);
    assign n_wr      = r_wr + PTR_W'(i_push.count);
    assign n_rd      = r_rd + PTR_W'(i_pop);
    assign n_count   = r_count + CNT_W'(i_push.count) - CNT_W'(i_pop);

    // room for the two results a request may cause
    assign o_ready = r_count <= CNT_W'(FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (CNT_W'(r_count) <= CNT_W'(FIFO_DEPTH - 2)))
        else $error("result queue overflow");

endmodule

@@ design/adv_data_name_extractor.sv @@
`timescale 1ns / 1ps

// channel   dir  fields                                                  handshake
// i_in      in   data_byte[7:0] frame_len[5:0] frame_last                valid/ready
// o_out     out  kind name_char[7:0] name_found name_length[5:0] run_last valid/ready
// i_cfg     in   i_cfg_wr_data[5:0] = max_name_len                       i_cfg_wr_en
//
// One input request per cycle while i_in.ready is high; its results land in a 4-deep result queue
// the next cycle. A request causes up to two results; the queue drains one per cycle while o_out.ready is high.
// i_in.ready drops only when the result queue has fewer than two free entries.
// Synchronous active-low reset clears parse state, queue and sets max_name_len to 31.

module adv_data_name_extractor
    import adne_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 62
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adne_in_if.sink     i_in,
    adne_out_if.source  o_out,
    input  logic        i_cfg_wr_en,
    input  logic [5:0]  i_cfg_wr_data
);

    logic       r_max_name_len;
    logic [5:0] r_max_len;
    logic       w_fire;
    logic       w_pop;
    logic       w_ready;
    t_push      w_push;
    t_result    w_head;

    assign w_fire     = i_in.valid && w_ready;
    assign i_in.ready = w_ready;
    assign w_pop      = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len      <= MAX_NAME_LEN_RST;
            r_max_name_len <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_max_len      <= i_cfg_wr_data;
            r_max_name_len <= 1'b1;
        end
    end

    adne_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_data_byte    (i_in.data_byte),
        .i_frame_len    (i_in.frame_len),
        .i_frame_last   (i_in.frame_last),
        .i_max_name_len (r_max_len),
        .o_push         (w_push)
    );

    adne_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_ready (w_ready),
        .o_valid (o_out.valid),
        .o_head  (w_head)
    );

    assign o_out.kind        = w_head.kind;
    assign o_out.name_char   = w_head.name_char;
    assign o_out.name_found  = w_head.name_found;
    assign o_out.name_length = w_head.name_length;
    assign o_out.run_last    = w_head.run_last;

    a_cfg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_max_name_len && r_max_len == $past(i_cfg_wr_data)))
        else $error("max_name_len write lost");

endmodule
